// ----- rtl/pdp11_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// PDP-11 instruction decoder package
// Payload types, stage-to-stage structs and the constant opcode tables.
// ----------------------------------------------------------------------------
package pdp11_dec_pkg;

   localparam int TABLE_SIZE = 87;
   localparam int IDX_W      = 7;

   typedef enum logic [3:0] {
      FORM_DOUBLE     = 4'd0,
      FORM_SINGLE     = 4'd1,
      FORM_WSINGLE    = 4'd2,
      FORM_MULDIV     = 4'd3,
      FORM_BRANCH     = 4'd4,
      FORM_NONE       = 4'd5,
      FORM_FLOAT_REV  = 4'd6,
      FORM_FLOAT_NORM = 4'd7,
      FORM_REG_DST    = 4'd8,
      FORM_RTS        = 4'd9,
      FORM_RAW        = 4'd10,
      FORM_EMT        = 4'd11,
      FORM_SYS        = 4'd12,
      FORM_MARK       = 4'd13,
      FORM_SOB        = 4'd14,
      FORM_SPL        = 4'd15
   } form_type;

   typedef struct packed {
      logic [15:0] instr_word;
      logic [15:0] instr_addr;
      logic        is_nested;
   } req_type;

   typedef struct packed {
      logic [6:0]  mnemonic_index;
      form_type    operand_form;
      logic        byte_op;
      logic [1:0]  operand_count;
      logic [2:0]  first_mode;
      logic [2:0]  first_reg;
      logic [2:0]  second_mode;
      logic [2:0]  second_reg;
      logic [15:0] literal_value;
      logic [15:0] branch_target;
      logic [2:0]  extension_words;
      logic        indirect_follows;
   } rsp_type;

   // Between the match stage and the priority encoder.
   typedef struct packed {
      logic                  valid;
      logic [TABLE_SIZE-1:0] hit;
      req_type               req;
   } match_stage_type;

   // Between the priority encoder and the field formatter.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      form_type         form;
      req_type          req;
   } encode_stage_type;

   // Bits that are don't-care for each table entry.
   localparam logic [15:0] OP_MASK [TABLE_SIZE] = '{
      16'o107777, 16'o107777, 16'o107777, 16'o107777, 16'o107777, 16'o007777,
      16'o007777,
      16'o100077, 16'o100077, 16'o100077, 16'o100077, 16'o100077, 16'o100077,
      16'o100077, 16'o100077, 16'o100077, 16'o100077, 16'o100077, 16'o100077,
      16'o000077, 16'o000077,
      16'o000077, 16'o000077, 16'o000077, 16'o000077, 16'o000077, 16'o000077,
      16'o000077, 16'o000077, 16'o000077, 16'o000077, 16'o000077, 16'o000077,
      16'o000777, 16'o000777, 16'o000777, 16'o000777,
      16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377,
      16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377,
      16'o000377, 16'o000377, 16'o000377,
      16'o000000, 16'o000000, 16'o000000, 16'o000000, 16'o000000,
      16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377,
      16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377, 16'o000377,
      16'o000377, 16'o000377,
      16'o000000, 16'o000000, 16'o000000, 16'o000000, 16'o000000,
      16'o000777, 16'o000777,
      16'o000007,
      16'o000017, 16'o000017,
      16'o000377,
      16'o000377,
      16'o000077,
      16'o000777,
      16'o000007,
      16'o177777
   };

   localparam logic [15:0] OP_VALUE [TABLE_SIZE] = '{
      16'o010000, 16'o020000, 16'o030000, 16'o040000, 16'o050000, 16'o060000,
      16'o160000,
      16'o005000, 16'o005100, 16'o005200, 16'o005300, 16'o005400, 16'o005500,
      16'o005600, 16'o005700, 16'o006000, 16'o006100, 16'o006200, 16'o006300,
      16'o000100, 16'o000300,
      16'o170100, 16'o170200, 16'o170300, 16'o170400, 16'o170500, 16'o170600,
      16'o170700, 16'o006700, 16'o006600, 16'o106600, 16'o006500, 16'o106500,
      16'o070000, 16'o071000, 16'o072000, 16'o073000,
      16'o000400, 16'o001000, 16'o001400, 16'o002000, 16'o002400, 16'o003000,
      16'o003400, 16'o100000, 16'o100400, 16'o101000, 16'o101400, 16'o102000,
      16'o102400, 16'o103000, 16'o103400,
      16'o000000, 16'o000001, 16'o000002, 16'o000004, 16'o000005,
      16'o171000, 16'o171400, 16'o172000, 16'o172400, 16'o173000, 16'o173400,
      16'o174000, 16'o174400, 16'o175000, 16'o175400, 16'o176000, 16'o176400,
      16'o177000, 16'o177400,
      16'o170000, 16'o170001, 16'o170002, 16'o170011, 16'o170012,
      16'o004000, 16'o074000,
      16'o000200,
      16'o000240, 16'o000260,
      16'o104000,
      16'o104400,
      16'o006400,
      16'o077000,
      16'o000230,
      16'o000000
   };

   localparam form_type OP_FORM [TABLE_SIZE] = '{
      FORM_DOUBLE, FORM_DOUBLE, FORM_DOUBLE, FORM_DOUBLE, FORM_DOUBLE,
      FORM_DOUBLE, FORM_DOUBLE,
      FORM_SINGLE, FORM_SINGLE, FORM_SINGLE, FORM_SINGLE, FORM_SINGLE,
      FORM_SINGLE, FORM_SINGLE, FORM_SINGLE, FORM_SINGLE, FORM_SINGLE,
      FORM_SINGLE, FORM_SINGLE,
      FORM_SINGLE, FORM_SINGLE,
      FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE,
      FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE, FORM_WSINGLE,
      FORM_WSINGLE, FORM_WSINGLE,
      FORM_MULDIV, FORM_MULDIV, FORM_MULDIV, FORM_MULDIV,
      FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH,
      FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH,
      FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH, FORM_BRANCH,
      FORM_NONE, FORM_NONE, FORM_NONE, FORM_NONE, FORM_NONE,
      FORM_FLOAT_REV, FORM_FLOAT_REV, FORM_FLOAT_REV, FORM_FLOAT_REV,
      FORM_FLOAT_REV, FORM_FLOAT_REV, FORM_FLOAT_NORM, FORM_FLOAT_REV,
      FORM_FLOAT_NORM, FORM_FLOAT_NORM, FORM_FLOAT_NORM, FORM_FLOAT_REV,
      FORM_FLOAT_REV, FORM_FLOAT_REV,
      FORM_NONE, FORM_NONE, FORM_NONE, FORM_NONE, FORM_NONE,
      FORM_REG_DST, FORM_REG_DST,
      FORM_RTS,
      FORM_RAW, FORM_RAW,
      FORM_EMT,
      FORM_SYS,
      FORM_MARK,
      FORM_SOB,
      FORM_SPL,
      FORM_RAW
   };

   // Argument words that follow each system call.
   localparam logic [2:0] CALL_ARGS [64] = '{
      3'd1, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0,
      3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2,
      3'd2, 3'd1, 3'd2, 3'd2, 3'd0, 3'd3, 3'd1, 3'd0,
      3'd0, 3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0,
      3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

endpackage

// ----- rtl/pdp11_dec_match.sv -----
// ----------------------------------------------------------------------------
// PDP-11 decoder, match stage
// Compares the word against every opcode table entry in parallel.
// ----------------------------------------------------------------------------
module pdp11_dec_match
   import pdp11_dec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_type         in_req,
   output match_stage_type out_stage
);

   logic [TABLE_SIZE-1:0] hit_in;
   logic                  valid_ff;
   logic [TABLE_SIZE-1:0] hit_ff;
   req_type               req_ff;

   for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
      assign hit_in[i] = ((in_req.instr_word & ~OP_MASK[i]) == OP_VALUE[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      req_ff <= in_req;
   end

   assign out_stage.valid = valid_ff;
   assign out_stage.hit   = hit_ff;
   assign out_stage.req   = req_ff;

endmodule

// ----- rtl/pdp11_dec_encode.sv -----
// ----------------------------------------------------------------------------
// PDP-11 decoder, priority encode stage
// Picks the lowest matching table entry and looks up its operand form.
// ----------------------------------------------------------------------------
module pdp11_dec_encode
   import pdp11_dec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  match_stage_type  in_stage,
   output encode_stage_type out_stage
);

   logic [IDX_W-1:0] idx_in;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;
   form_type         form_ff;
   req_type          req_ff;

   // The last entry matches every word, so it is the fallback.
   always_comb begin
      idx_in = IDX_W'(TABLE_SIZE - 1);
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (in_stage.hit[i]) begin
            idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      form_ff <= OP_FORM[idx_in];
      req_ff  <= in_stage.req;
   end

   assign out_stage.valid = valid_ff;
   assign out_stage.idx   = idx_ff;
   assign out_stage.form  = form_ff;
   assign out_stage.req   = req_ff;

endmodule

// ----- rtl/pdp11_dec_format.sv -----
// ----------------------------------------------------------------------------
// PDP-11 decoder, operand format stage
// Extracts operands, literal, branch target and extension word count.
// ----------------------------------------------------------------------------
module pdp11_dec_format
   import pdp11_dec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  encode_stage_type in_stage,
   output logic             out_strobe,
   output rsp_type          out_rsp
);

   function automatic logic op_words(input logic [2:0] mode, input logic [2:0] rn);
      logic indexed;
      logic pc_immediate;
      indexed      = (mode >= 3'd6);
      pc_immediate = ((mode == 3'd2) || (mode == 3'd3)) && (rn == 3'd7);
      return indexed || pc_immediate;
   endfunction

   logic [15:0] w;
   logic [15:0] addr_plus2;
   logic [15:0] br_offset;
   logic [15:0] sob_offset;
   logic [5:0]  call_num;
   logic [2:0]  base_ext;
   rsp_type     rsp_in;
   logic        strobe_ff;
   rsp_type     rsp_ff;

   assign w          = in_stage.req.instr_word;
   assign addr_plus2 = in_stage.req.instr_addr + 16'd2;
   assign br_offset  = {{7{w[7]}}, w[7:0], 1'b0};
   assign sob_offset = {9'd0, w[5:0], 1'b0};
   assign call_num   = w[5:0];

   always_comb begin
      rsp_in                = '0;
      base_ext              = 3'd0;
      rsp_in.mnemonic_index = in_stage.idx;
      rsp_in.operand_form   = in_stage.form;
      unique case (in_stage.form)
         FORM_DOUBLE: begin
            rsp_in.byte_op       = w[15];
            rsp_in.first_mode    = w[11:9];
            rsp_in.first_reg     = w[8:6];
            rsp_in.second_mode   = w[5:3];
            rsp_in.second_reg    = w[2:0];
            rsp_in.operand_count = 2'd2;
         end
         FORM_SINGLE, FORM_WSINGLE: begin
            rsp_in.byte_op       = (in_stage.form == FORM_SINGLE) ? w[15] : 1'b0;
            rsp_in.first_mode    = w[5:3];
            rsp_in.first_reg     = w[2:0];
            rsp_in.operand_count = 2'd1;
         end
         FORM_MULDIV, FORM_FLOAT_REV: begin
            rsp_in.first_mode    = w[5:3];
            rsp_in.first_reg     = w[2:0];
            rsp_in.second_reg    = {(in_stage.form == FORM_MULDIV) & w[8], w[7:6]};
            rsp_in.operand_count = 2'd2;
         end
         FORM_FLOAT_NORM, FORM_REG_DST: begin
            rsp_in.first_reg     = {(in_stage.form == FORM_REG_DST) & w[8], w[7:6]};
            rsp_in.second_mode   = w[5:3];
            rsp_in.second_reg    = w[2:0];
            rsp_in.operand_count = 2'd2;
         end
         FORM_RTS: begin
            rsp_in.first_reg     = w[2:0];
            rsp_in.operand_count = 2'd1;
         end
         FORM_BRANCH: begin
            rsp_in.branch_target = addr_plus2 + br_offset;
         end
         FORM_SOB: begin
            rsp_in.first_reg     = w[8:6];
            rsp_in.operand_count = 2'd1;
            rsp_in.branch_target = addr_plus2 - sob_offset;
         end
         FORM_RAW: begin
            rsp_in.literal_value = w;
         end
         FORM_EMT: begin
            rsp_in.literal_value = {8'd0, w[7:0]};
         end
         FORM_MARK: begin
            rsp_in.literal_value = {10'd0, w[5:0]};
         end
         FORM_SPL: begin
            rsp_in.literal_value = {13'd0, w[2:0]};
         end
         FORM_SYS: begin
            rsp_in.literal_value = {10'd0, call_num};
            // Call zero outside nesting is the indirect form: one pointer word.
            if ((call_num == 6'd0) && !in_stage.req.is_nested) begin
               base_ext                = 3'd1;
               rsp_in.indirect_follows = 1'b1;
            end else begin
               base_ext = CALL_ARGS[call_num];
            end
         end
         FORM_NONE: begin
         end
         default: begin
         end
      endcase
      rsp_in.extension_words = base_ext
         + {2'd0, (rsp_in.operand_count != 2'd0)
                  & op_words(rsp_in.first_mode, rsp_in.first_reg)}
         + {2'd0, (rsp_in.operand_count == 2'd2)
                  & op_words(rsp_in.second_mode, rsp_in.second_reg)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

// ----- rtl/pdp11_instruction_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// PDP-11 instruction decoder unit
// Decodes one 16-bit instruction word into mnemonic, operands and targets.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the instruction word, its byte address and the nested
//   flag on req_item. A transaction is taken at every clock edge where start
//   is high and busy is low. Busy never rises, so a new word can be given
//   every cycle.
//   Each decoded result appears on rsp_item for exactly one cycle, marked by
//   rsp_strobe, after its transaction has passed the match, encode and format
//   stage registers in that order. Results come out in the order the words
//   went in, one per word.
//   Throughput is one word per cycle. The three stages are the table match,
//   the first-match priority encoder with the form lookup, and the operand
//   extraction with the branch-target adder.
//   Reset clears the stage valid bits, so no strobe follows reset until a new
//   word is taken. The receiver must take each result in the cycle it is
//   shown; there is no back pressure on the result side.
// ----------------------------------------------------------------------------
module pdp11_instruction_decoder_unit
   import pdp11_dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   match_stage_type  match_stage;
   encode_stage_type encode_stage;

   // Every stage advances each cycle, so the decoder is always ready.
   assign busy = 1'b0;

   pdp11_dec_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_item),
      .out_stage (match_stage)
   );

   pdp11_dec_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (match_stage),
      .out_stage (encode_stage)
   );

   pdp11_dec_format u_format (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (encode_stage),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_item)
   );

endmodule

// ----- rtl/pdp11_dec_checker.sv -----
// ----------------------------------------------------------------------------
// PDP-11 decoder port checker
// Watches the top level ports for latency and result consistency.
// ----------------------------------------------------------------------------
module pdp11_dec_checker
   import pdp11_dec_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Every taken transaction produces a result once it has passed the match, encode and format stages.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result missing three cycles after a transaction");

   // No result appears without a taken transaction that passed the match, encode and format stages.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result without a matching transaction");

   // Only branch and loop forms carry a target.
   a_target_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.branch_target != 16'd0)) |->
         ((rsp_item.operand_form == FORM_BRANCH) || (rsp_item.operand_form == FORM_SOB)))
      else $error("branch target on a form without one");

   // An indirect call is only flagged outside nesting and takes one word.
   a_indirect: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.indirect_follows) |->
         (!$past(req_item.is_nested, 3) && (rsp_item.extension_words == 3'd1)
          && (rsp_item.operand_form == FORM_SYS)))
      else $error("indirect call flag inconsistent with its transaction");

endmodule

bind pdp11_instruction_decoder_unit pdp11_dec_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
